// ===== hw/rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit.
// Holds widths, command codes, controller state type and command/status structs.
// No dependencies.
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W = 2 * OPERAND_WIDTH;
  localparam int MAG_W = 2 * OPERAND_WIDTH + 2;
  localparam int CNT_W = $clog2(MAG_W + 1);
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;
  localparam int CMD_W = 3;

  localparam logic [CMD_W-1:0] CMD_NORM = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_EQ   = 3'd5;

  typedef enum logic [1:0] {
    SEL_GCD,
    SEL_NUM,
    SEL_DEN
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_FORM,
    ST_GCD,
    ST_GCD_WAIT,
    ST_QN_WAIT,
    ST_QD_START,
    ST_QD_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    logic [1:0] mul_idx;
    logic     form;
    logic     div_start;
    div_sel_t div_sel;
    logic     gcd_take;
    logic     qn_take;
    logic     qd_take;
    logic     fin;
  } dp_cmd_t;

  typedef struct packed {
    logic shortcut;
    logic gy_zero;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hw/rtl/rau_if.sv =====
// Handshake channel interfaces for the rational arithmetic unit.
// Depends on rau_pkg.
interface rau_in_if;
  import rau_pkg::*;
  logic valid;
  logic ready;
  logic [CMD_W-1:0] cmd;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;
  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;
  logic valid;
  logic ready;
  logic signed [NUM_W-1:0] res_num;
  logic [DEN_W-1:0] res_den;
  logic is_equal;
  logic err;
  modport source (output valid, res_num, res_den, is_equal, err, input ready);
  modport sink (input valid, res_num, res_den, is_equal, err, output ready);
endinterface

// ===== hw/rtl/rau_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rau_pkg::MAG_W-1:0]   dividend,
  input  logic [rau_pkg::MAG_W-1:0]   divisor,
  output logic [rau_pkg::MAG_W-1:0]   quo,
  output logic [rau_pkg::MAG_W-1:0]   rem,
  output logic                        done
);
  import rau_pkg::*;

  logic [MAG_W-1:0] quo_r, rem_r, dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [MAG_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[MAG_W-1]};
  assign fits = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MAG_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[MAG_W-2:0], fits};
      rem_r <= fits ? MAG_W'(trial - {1'b0, dvs_r}) : trial[MAG_W-1:0];
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;
endmodule

// ===== hw/rtl/rau_ctrl.sv =====
// Controller state machine: sequences products, GCD loop and the two divisions.
// Depends on rau_pkg.
module rau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rau_pkg::dp_stat_t stat,
  output rau_pkg::dp_cmd_t  cmd
);
  import rau_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_MUL0;
      ST_MUL0:     state_nxt = ST_MUL1;
      ST_MUL1:     state_nxt = ST_MUL2;
      ST_MUL2:     state_nxt = ST_FORM;
      ST_FORM:     state_nxt = ST_GCD;
      ST_GCD: begin
        if (stat.shortcut) state_nxt = ST_FIN;
        else if (stat.gy_zero) state_nxt = ST_QN_WAIT;
        else state_nxt = ST_GCD_WAIT;
      end
      ST_GCD_WAIT: if (stat.div_done) state_nxt = ST_GCD;
      ST_QN_WAIT:  if (stat.div_done) state_nxt = ST_QD_START;
      ST_QD_START: state_nxt = ST_QD_WAIT;
      ST_QD_WAIT:  if (stat.div_done) state_nxt = ST_FIN;
      ST_FIN:      if (stat.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = SEL_GCD;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL0: begin
        cmd.mul_en = 1'b1;
        cmd.mul_idx = 2'd0;
      end
      ST_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_idx = 2'd1;
      end
      ST_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_idx = 2'd2;
      end
      ST_FORM: cmd.form = 1'b1;
      ST_GCD: begin
        if (!stat.shortcut) begin
          cmd.div_start = 1'b1;
          cmd.div_sel = stat.gy_zero ? SEL_NUM : SEL_GCD;
        end
      end
      ST_GCD_WAIT: cmd.gcd_take = stat.div_done;
      ST_QN_WAIT:  cmd.qn_take = stat.div_done;
      ST_QD_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = SEL_DEN;
      end
      ST_QD_WAIT:  cmd.qd_take = stat.div_done;
      ST_FIN:      cmd.fin = stat.out_free;
      default:     cmd = '0;
    endcase
  end
endmodule

// ===== hw/rtl/rau_dp.sv =====
// Datapath: operand registers, product sequencing, GCD and quotient registers,
// output register. Depends on rau_pkg, rau_if and rau_div.
module rau_dp (
  input  logic              clk,
  input  logic              rst_n,
  rau_in_if.sink            in_ch,
  rau_out_if.source         out_ch,
  input  rau_pkg::dp_cmd_t  cmd,
  output rau_pkg::dp_stat_t stat
);
  import rau_pkg::*;

  localparam logic signed [OPERAND_WIDTH-1:0] ONE = OPERAND_WIDTH'(1);

  logic [CMD_W-1:0] op_r;
  logic signed [OPERAND_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic [MAG_W-1:0] nm_r, dm_r, gx_r, gy_r, qn_r, qd_r;
  logic neg_r, bad_r, cmp_r, zero_r, eq_r;
  logic out_valid_r;
  logic signed [NUM_W-1:0] out_num_r;
  logic [DEN_W-1:0] out_den_r;
  logic out_eq_r, out_err_r;

  logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [MAG_W-1:0] num_s, den_s, qs;
  logic [MAG_W-1:0] dvd, dvs, quo, rem;
  logic div_done, bad;

  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    case (cmd.mul_idx)
      2'd0: begin
        if (op_r == CMD_NORM) mul_b = ONE;
        else if (op_r == CMD_MUL) mul_b = bn_r;
      end
      2'd1: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      default: begin
        mul_a = ad_r;
        if (op_r == CMD_NORM) mul_b = ONE;
        else if (op_r == CMD_DIV) mul_b = bn_r;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (op_r)
      CMD_ADD: num_s = MAG_W'(p0_r) + MAG_W'(p1_r);
      CMD_SUB: num_s = MAG_W'(p0_r) - MAG_W'(p1_r);
      default: num_s = MAG_W'(p0_r);
    endcase
    den_s = MAG_W'(p2_r);
  end

  assign bad = (op_r > CMD_EQ) || (ad_r == '0) || ((op_r != CMD_NORM) && (bd_r == '0))
               || ((op_r == CMD_DIV) && (bn_r == '0));

  always_comb begin
    case (cmd.div_sel)
      SEL_GCD: begin
        dvd = gx_r;
        dvs = gy_r;
      end
      SEL_NUM: begin
        dvd = nm_r;
        dvs = gx_r;
      end
      default: begin
        dvd = dm_r;
        dvs = gx_r;
      end
    endcase
  end

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quo      (quo),
    .rem      (rem),
    .done     (div_done)
  );

  assign qs = neg_r ? -signed'(qn_r) : signed'(qn_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_ch.cmd;
      an_r <= in_ch.a_num;
      ad_r <= in_ch.a_den;
      bn_r <= in_ch.b_num;
      bd_r <= in_ch.b_den;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_idx)
        2'd0:    p0_r <= prod;
        2'd1:    p1_r <= prod;
        default: p2_r <= prod;
      endcase
    end
    if (cmd.form) begin
      nm_r   <= num_s[MAG_W-1] ? MAG_W'(-num_s) : MAG_W'(num_s);
      dm_r   <= den_s[MAG_W-1] ? MAG_W'(-den_s) : MAG_W'(den_s);
      gx_r   <= num_s[MAG_W-1] ? MAG_W'(-num_s) : MAG_W'(num_s);
      gy_r   <= den_s[MAG_W-1] ? MAG_W'(-den_s) : MAG_W'(den_s);
      neg_r  <= num_s[MAG_W-1] ^ den_s[MAG_W-1];
      bad_r  <= bad;
      cmp_r  <= op_r == CMD_EQ;
      zero_r <= num_s == '0;
      eq_r   <= p0_r == p1_r;
    end
    if (cmd.gcd_take) begin
      gx_r <= gy_r;
      gy_r <= rem;
    end
    if (cmd.qn_take) qn_r <= quo;
    if (cmd.qd_take) qd_r <= quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_eq_r  <= cmp_r && !bad_r && eq_r;
      out_err_r <= bad_r;
      if (bad_r || cmp_r || zero_r) begin
        out_num_r <= '0;
        out_den_r <= DEN_W'(1);
      end else begin
        out_num_r <= NUM_W'(qs);
        out_den_r <= DEN_W'(qd_r);
      end
    end
  end

  assign stat.shortcut = bad_r || cmp_r || zero_r;
  assign stat.gy_zero  = gy_r == '0;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.res_num  = out_num_r;
  assign out_ch.res_den  = out_den_r;
  assign out_ch.is_equal = out_eq_r;
  assign out_ch.err      = out_err_r;
endmodule

// ===== hw/rtl/rational_arith_unit.sv =====
// Rational arithmetic unit top level: controller plus datapath.
// Sequence: product states MUL0 to MUL2 and FORM, then a divider run per Euclid step and one for
// each of the two reducing divisions; the bit-serial divider sets the pace (MAG_W = 34).
// Error, equal and zero results skip the divider and go straight to the finish state.
// One item at a time; a finished beat waits in the output register.
// Synchronous active-low reset clears controller state and output valid.
module rational_arith_unit (
  input  logic      clk,
  input  logic      rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rau_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );
endmodule

// ===== tb/rational_arith_unit_test.sv =====
// Self-checking testbench for rational_arith_unit: a directed table of fraction commands,
// then random fractions, with each result beat checked against its typed answer or a local fraction model.
// Depends on rau_pkg, rau_if and the rational_arith_unit RTL.
module rational_arith_unit_test;
  import rau_pkg::*;

  localparam int LIMIT_CYCLES = 10000000;
  localparam int N_RANDOM = 1030;
  localparam logic [CMD_W-1:0] CMD_BAD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BAD7 = 3'd7;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic signed [OPERAND_WIDTH-1:0] an, ad, bn, bd;
  } frac_op_t;

  typedef struct {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic eq;
    logic err;
  } frac_res_t;

  typedef struct {
    frac_op_t op;
    bit typed;
    frac_res_t res;
  } table_row_t;

  logic clk = 0;
  logic rst_n = 0;
  rau_in_if in_ch();
  rau_out_if out_ch();

  rational_arith_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  frac_res_t pending_results[$];
  int n_errors = 0;
  int n_results = 0;
  int n_sent = 0;
  int cycle_count = 0;
  bit sending_done = 0;
  bit long_hold = 0;
  bit no_idle = 0;
  int n_err_seen = 0;
  int n_eq_seen = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic void lowest_terms(input longint n, input longint d,
                                       output longint rn, output longint rd);
    longint unsigned g;
    if (n == 0) begin
      rn = 0;
      rd = 1;
      return;
    end
    g = gcd64(n < 0 ? -n : n, d < 0 ? -d : d);
    n = n / longint'(g);
    d = d / longint'(g);
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    rn = n;
    rd = d;
  endfunction

  function automatic frac_res_t frac_compute(frac_op_t op);
    frac_res_t r;
    longint pn, pd, qn, qd, n, d;
    bit e, q;
    pn = 0; pd = 1; qn = 0; qd = 1; n = 0; d = 1;
    e = 0; q = 0;
    if (op.cmd > CMD_EQ) begin
      e = 1;
    end else if (op.ad == 0 || (op.cmd != CMD_NORM && op.bd == 0)) begin
      e = 1;
    end else begin
      lowest_terms(op.an, op.ad, pn, pd);
      if (op.cmd != CMD_NORM) lowest_terms(op.bn, op.bd, qn, qd);
      case (op.cmd)
        CMD_NORM: begin
          n = pn;
          d = pd;
        end
        CMD_ADD: lowest_terms(pn * qd + qn * pd, pd * qd, n, d);
        CMD_SUB: lowest_terms(pn * qd - qn * pd, pd * qd, n, d);
        CMD_MUL: lowest_terms(pn * qn, pd * qd, n, d);
        CMD_DIV: begin
          if (qn == 0) e = 1;
          else lowest_terms(pn * qd, pd * qn, n, d);
        end
        default: q = (pn == qn) && (pd == qd);
      endcase
    end
    if (e) begin
      n = 0;
      d = 1;
      q = 0;
    end
    r.num = n[NUM_W-1:0];
    r.den = d[DEN_W-1:0];
    r.eq = q;
    r.err = e;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d on result %0d: %s got %0d want %0d",
             cycle_count, n_results, what, got, want);
    n_errors++;
  endtask

  function automatic logic signed [OPERAND_WIDTH-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return OPERAND_WIDTH'($urandom_range(0, 3));
      2: return -$signed({1'b0, 15'($urandom_range(1, 12))});
      3: return OPERAND_WIDTH'($signed(16'($urandom_range(0, 64)))
                               * ($urandom_range(0, 1) ? 1 : -1));
      default: return OPERAND_WIDTH'($urandom);
    endcase
  endfunction

  function automatic frac_op_t rand_op();
    frac_op_t op;
    int pick;
    pick = $urandom_range(0, 99);
    op.cmd = pick < 3 ? CMD_W'($urandom_range(6, 7)) : CMD_W'($urandom_range(0, 5));
    op.an = rand_operand();
    op.ad = rand_operand();
    op.bn = rand_operand();
    op.bd = rand_operand();
    if (op.ad == 0 && $urandom_range(0, 3) != 0) op.ad = 1;
    if (op.bd == 0 && $urandom_range(0, 3) != 0) op.bd = -1;
    if (op.cmd == CMD_EQ && $urandom_range(0, 1)) begin
      op.bn = OPERAND_WIDTH'(op.an * 3);
      op.bd = OPERAND_WIDTH'(op.ad * 3);
      if ($urandom_range(0, 1)) begin
        op.bn = -op.an;
        op.bd = -op.ad;
      end
    end
    return op;
  endfunction

  task automatic send_beat(frac_op_t op, bit typed, frac_res_t want);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= op.cmd;
    in_ch.a_num <= op.an;
    in_ch.a_den <= op.ad;
    in_ch.b_num <= op.bn;
    in_ch.b_den <= op.bd;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(typed ? want : frac_compute(op));
    n_sent++;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  function automatic table_row_t row(logic [CMD_W-1:0] c, int an, int ad, int bn, int bd,
                                     bit typed = 0, longint num = 0, longint den = 1,
                                     bit eq = 0, bit err = 0);
    table_row_t r;
    r.op.cmd = c;
    r.op.an = OPERAND_WIDTH'(an);
    r.op.ad = OPERAND_WIDTH'(ad);
    r.op.bn = OPERAND_WIDTH'(bn);
    r.op.bd = OPERAND_WIDTH'(bd);
    r.typed = typed;
    r.res.num = NUM_W'(num);
    r.res.den = DEN_W'(den);
    r.res.eq = eq;
    r.res.err = err;
    return r;
  endfunction

  initial begin
    table_row_t directed[$];
    frac_res_t none;
    none = '{num: 0, den: 1, eq: 0, err: 0};
    in_ch.valid = 0;
    in_ch.cmd = CMD_NORM;
    in_ch.a_num = 0;
    in_ch.a_den = 1;
    in_ch.b_num = 0;
    in_ch.b_den = 1;
    directed.push_back(row(CMD_NORM, 6, -4, 0, 0, 1, -3, 2));
    directed.push_back(row(CMD_NORM, 0, -7, 0, 0, 1, 0, 1));
    directed.push_back(row(CMD_NORM, 5, 0, 1, 1, 1, 0, 1, 0, 1));
    directed.push_back(row(CMD_ADD, 1, 2, 1, 0, 1, 0, 1, 0, 1));
    directed.push_back(row(CMD_ADD, 1, 2, 1, 3, 1, 5, 6));
    directed.push_back(row(CMD_SUB, 1, 2, 1, 2, 1, 0, 1));
    directed.push_back(row(CMD_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1));
    directed.push_back(row(CMD_MUL, 1, -32768, 1, 32767, 1, -1, 1073709056));
    directed.push_back(row(CMD_ADD, 32767, 1, 32767, 1, 1, 65534, 1));
    directed.push_back(row(CMD_SUB, -32768, 1, 32767, 1, 1, -65535, 1));
    directed.push_back(row(CMD_DIV, 3, 4, 0, 5, 1, 0, 1, 0, 1));
    directed.push_back(row(CMD_DIV, -32768, 1, 1, -32768, 1, 1073741824, 1));
    directed.push_back(row(CMD_DIV, 2, 3, -4, 9, 1, -3, 2));
    directed.push_back(row(CMD_EQ, 2, 4, -3, -6, 1, 0, 1, 1, 0));
    directed.push_back(row(CMD_EQ, 0, 4, 0, -9, 1, 0, 1, 1, 0));
    directed.push_back(row(CMD_EQ, 1, 3, 1, 4, 1, 0, 1, 0, 0));
    directed.push_back(row(CMD_EQ, 1, 3, 1, 0, 1, 0, 1, 0, 1));
    directed.push_back(row(CMD_BAD6, 1, 1, 1, 1, 1, 0, 1, 0, 1));
    directed.push_back(row(CMD_BAD7, 2, 3, 4, 5, 1, 0, 1, 0, 1));
    directed.push_back(row(CMD_SUB, -32768, -32768, 32767, -32768));
    directed.push_back(row(CMD_ADD, -1, 32767, 1, -32768));
    directed.push_back(row(CMD_NORM, 32767, -32768, 0, 0));
    directed.push_back(row(CMD_MUL, 0, 5, -7, 3, 1, 0, 1));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_beat(directed[i].op, directed[i].typed, directed[i].res);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) begin
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      if (i == 500) long_hold = 1;
      if (i == N_RANDOM - 150) no_idle = 1;
      send_beat(rand_op(), 0, none);
    end
    in_ch.valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frac_res_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("unexpected result beat at cycle %0d", cycle_count);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.res_num !== want.num) report_mismatch("res_num", out_ch.res_num, want.num);
        if (out_ch.res_den !== want.den) report_mismatch("res_den", out_ch.res_den, want.den);
        if (out_ch.is_equal !== want.eq) report_mismatch("is_equal", out_ch.is_equal, want.eq);
        if (out_ch.err !== want.err) report_mismatch("err", out_ch.err, want.err);
        if (want.err) n_err_seen++;
        if (want.eq) n_eq_seen++;
      end
    end
  end

  initial begin
    wait (sending_done && pending_results.size() == 0);
    repeat (300) @(posedge clk);
    $display("covered %0d commands and %0d result beats, %0d errors and %0d equal answers",
             n_sent, n_results, n_err_seen, n_eq_seen);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rau_pkg.sv
hw/rtl/rau_if.sv
hw/rtl/rau_div.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rau_dp.sv
hw/rtl/rational_arith_unit.sv
tb/rational_arith_unit_test.sv
